/* rtl/core/jhsd_pkg.sv */
// Shared constants, codes and field widths for the JPEG Huffman symbol decoder.
package jhsd_pkg;

  localparam int LOOKAHEAD_BITS_DEF = 8;
  localparam int MAX_CODE_LEN_DEF   = 16;
  localparam int MAX_SYMBOLS_DEF    = 256;

  localparam int FUNC_W   = 2;
  localparam int BYTE_W   = 8;
  localparam int WIN_W    = 16;
  localparam int LEN_W    = 5;
  localparam int STATUS_W = 2;

  typedef logic [FUNC_W-1:0]   func_t;
  typedef logic [BYTE_W-1:0]   byte_t;
  typedef logic [WIN_W-1:0]    win_t;
  typedef logic [LEN_W-1:0]    len_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam func_t FUNC_LOAD_COUNT  = 2'd0;
  localparam func_t FUNC_LOAD_SYMBOL = 2'd1;
  localparam func_t FUNC_DECODE      = 2'd2;
  localparam func_t FUNC_UNUSED      = 2'd3;

  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_MORE   = 2'd1;
  localparam status_t ST_BAD    = 2'd2;
  localparam status_t ST_LOADED = 2'd3;

endpackage

/* rtl/core/jhsd_if.sv */
// Valid/ready channel interfaces for the decoder's item and result beats.
interface jhsd_in_if
  import jhsd_pkg::*;
  ();
  logic  valid;
  logic  ready;
  func_t func;
  byte_t entry_index;
  byte_t entry_value;
  win_t  window;
  len_t  avail;

  modport source (output valid, func, entry_index, entry_value, window, avail, input ready);
  modport sink   (input valid, func, entry_index, entry_value, window, avail, output ready);
endinterface

interface jhsd_out_if
  import jhsd_pkg::*;
  ();
  logic    valid;
  logic    ready;
  byte_t   symbol;
  len_t    code_length;
  status_t status;

  modport source (output valid, symbol, code_length, status, input ready);
  modport sink   (input valid, symbol, code_length, status, output ready);
endinterface

/* rtl/core/jpeg_huffman_symbol_decoder_unit.sv */
// JPEG canonical Huffman table store and bit-serial symbol decoder.
//
// Items arrive on in_chan (valid/ready); each one gives exactly one result
// beat on out_chan. Load items write one code count (func 0) or one symbol
// (func 1) and answer load done. A decode item (func 2) carries a 16-bit
// left-justified window and its valid bit count.
// The decoder shifts the window into a peek register one bit per cycle and
// checks one code length per cycle against the running canonical first code,
// so a code of length L is resolved at its L-th length step, followed by the
// symbol memory read and then the hand-over to the output register.
// Loads, unused codes and early need-more skip the length steps; a decode
// that stops at length L with need-more or invalid skips the memory read;
// the search ends at length MAX_CODE_LEN at the latest. One item is in
// flight at a time; the input is ready again as soon as its result is
// loaded into the output register, even if that result has not yet been
// taken.
// Reset clears the code counts and the output valid; the symbol memory is
// undefined until written. While out_chan stalls, the result is held and a
// finished item waits in the block until the output register frees up.
module jpeg_huffman_symbol_decoder_unit
  import jhsd_pkg::*;
#(
  parameter int LOOKAHEAD_BITS = LOOKAHEAD_BITS_DEF,
  parameter int MAX_CODE_LEN   = MAX_CODE_LEN_DEF,
  parameter int MAX_SYMBOLS    = MAX_SYMBOLS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  jhsd_in_if.sink   in_chan,
  jhsd_out_if.source out_chan
);

  localparam int CNT_IDX_W = $clog2(MAX_CODE_LEN);
  localparam int SYM_IDX_W = $clog2(MAX_SYMBOLS);
  localparam int CODE_W    = WIN_W + 1;
  localparam int POS_W     = 12;
  localparam int SPOS_W    = 13;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_r, state_nxt;

  byte_t counts_r [MAX_CODE_LEN];
  byte_t sym_mem  [MAX_SYMBOLS];
  byte_t sym_rd_r;

  win_t                 win_r, win_nxt;
  win_t                 peek_r, peek_nxt;
  len_t                 avail_r, avail_nxt;
  len_t                 len_r, len_nxt;
  logic [CNT_IDX_W-1:0] cidx_r, cidx_nxt;
  logic [CODE_W-1:0]    code_r, code_nxt;
  logic                 big_r, big_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;

  byte_t   res_symbol_r, res_symbol_nxt;
  len_t    res_len_r, res_len_nxt;
  status_t res_status_r, res_status_nxt;

  logic    out_valid_r, out_valid_nxt;
  byte_t   out_symbol_r;
  len_t    out_len_r;
  status_t out_status_r;

  logic                 accept;
  logic                 out_free;
  logic                 rd_en;
  logic [SYM_IDX_W-1:0] rd_addr;
  len_t                 avail_sat;

  win_t              peek_cur;
  byte_t             cnt;
  logic [CODE_W-1:0] diff;
  logic              match;
  logic [SPOS_W-1:0] spos;
  logic [CODE_W:0]   sum;

  assign in_chan.ready = (state_r == S_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;

  assign avail_sat = (in_chan.avail > len_t'(WIN_W)) ? len_t'(WIN_W) : in_chan.avail;

  // one length per step: the newest window bit joins the peek value
  assign peek_cur = {peek_r[WIN_W-2:0], win_r[WIN_W-1]};
  assign cnt      = counts_r[cidx_r];
  assign diff     = CODE_W'(peek_cur) - code_r;
  assign match    = !big_r && (cnt != '0) && (CODE_W'(peek_cur) >= code_r)
                    && (diff < CODE_W'(cnt));
  assign spos     = SPOS_W'(pos_r) + SPOS_W'(diff[BYTE_W-1:0]);
  assign sum      = (CODE_W+1)'(code_r) + (CODE_W+1)'(cnt);

  always_comb begin
    state_nxt      = state_r;
    win_nxt        = win_r;
    peek_nxt       = peek_r;
    avail_nxt      = avail_r;
    len_nxt        = len_r;
    cidx_nxt       = cidx_r;
    code_nxt       = code_r;
    big_nxt        = big_r;
    pos_nxt        = pos_r;
    res_symbol_nxt = res_symbol_r;
    res_len_nxt    = res_len_r;
    res_status_nxt = res_status_r;
    rd_en          = 1'b0;
    rd_addr        = spos[SYM_IDX_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_symbol_nxt = '0;
          res_len_nxt    = '0;
          state_nxt      = S_DONE;
          unique case (in_chan.func)
            FUNC_LOAD_COUNT, FUNC_LOAD_SYMBOL: res_status_nxt = ST_LOADED;
            FUNC_UNUSED:                       res_status_nxt = ST_BAD;
            FUNC_DECODE: begin
              if (avail_sat < len_t'(LOOKAHEAD_BITS) || avail_sat == '0) begin
                res_status_nxt = ST_MORE;
              end else begin
                state_nxt = S_RUN;
                win_nxt   = in_chan.window;
                peek_nxt  = '0;
                avail_nxt = avail_sat;
                len_nxt   = len_t'(1);
                cidx_nxt  = '0;
                code_nxt  = '0;
                big_nxt   = 1'b0;
                pos_nxt   = '0;
              end
            end
            default: res_status_nxt = ST_BAD;
          endcase
        end
      end

      S_RUN: begin
        priority if (len_r > len_t'(LOOKAHEAD_BITS) && avail_r < len_r) begin
          res_status_nxt = ST_MORE;
          state_nxt      = S_DONE;
        end else if (match) begin
          if (spos >= SPOS_W'(MAX_SYMBOLS)) begin
            res_status_nxt = ST_BAD;
            state_nxt      = S_DONE;
          end else begin
            rd_en          = 1'b1;
            res_len_nxt    = len_r;
            res_status_nxt = ST_OK;
            state_nxt      = S_READ;
          end
        end else if (len_r == len_t'(MAX_CODE_LEN)) begin
          res_status_nxt = ST_BAD;
          state_nxt      = S_DONE;
        end else begin
          // advance to the next length: first code doubles after the count
          peek_nxt = peek_cur;
          win_nxt  = {win_r[WIN_W-2:0], 1'b0};
          len_nxt  = len_r + len_t'(1);
          cidx_nxt = cidx_r + CNT_IDX_W'(1);
          pos_nxt  = pos_r + POS_W'(cnt);
          code_nxt = {sum[CODE_W-2:0], 1'b0};
          big_nxt  = big_r || sum[CODE_W] || sum[CODE_W-1];
        end
      end

      S_READ: begin
        res_symbol_nxt = sym_rd_r;
        state_nxt      = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (state_r == S_DONE && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_CODE_LEN; i++) begin
        counts_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept && in_chan.func == FUNC_LOAD_COUNT
          && {1'b0, in_chan.entry_index} < 9'(MAX_CODE_LEN)) begin
        counts_r[in_chan.entry_index[CNT_IDX_W-1:0]] <= in_chan.entry_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_chan.func == FUNC_LOAD_SYMBOL
        && {1'b0, in_chan.entry_index} < 9'(MAX_SYMBOLS)) begin
      sym_mem[in_chan.entry_index[SYM_IDX_W-1:0]] <= in_chan.entry_value;
    end
    if (rd_en) begin
      sym_rd_r <= sym_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    win_r        <= win_nxt;
    peek_r       <= peek_nxt;
    avail_r      <= avail_nxt;
    len_r        <= len_nxt;
    cidx_r       <= cidx_nxt;
    code_r       <= code_nxt;
    big_r        <= big_nxt;
    pos_r        <= pos_nxt;
    res_symbol_r <= res_symbol_nxt;
    res_len_r    <= res_len_nxt;
    res_status_r <= res_status_nxt;
    if (state_r == S_DONE && out_free) begin
      out_symbol_r <= res_symbol_r;
      out_len_r    <= res_len_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.symbol      = out_symbol_r;
  assign out_chan.code_length = out_len_r;
  assign out_chan.status      = out_status_r;

endmodule

/* rtl/core/jhsd_checker.sv */
// Port-level assertions for the Huffman symbol decoder, bound to the top level.
module jhsd_checker
  import jhsd_pkg::*;
#(
  parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
  input logic    clk,
  input logic    rst_n,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input byte_t   out_symbol,
  input len_t    out_code_length,
  input status_t out_status
);

  // a stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_symbol)
      && $stable(out_code_length) && $stable(out_status))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // one item at a time: an accepted beat closes the input
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready in the cycle after an accept");

  a_non_ok_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_symbol == '0 && out_code_length == '0)
    else $error("non-ok result carries symbol or length");

  a_ok_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OK
      |-> out_code_length != '0 && out_code_length <= len_t'(MAX_CODE_LEN))
    else $error("ok result with code length out of range");

endmodule

bind jpeg_huffman_symbol_decoder_unit jhsd_checker #(
  .MAX_CODE_LEN (MAX_CODE_LEN)
) u_jhsd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_symbol      (out_chan.symbol),
  .out_code_length (out_chan.code_length),
  .out_status      (out_chan.status)
);
